// ----- rtl/core/tom_pkg.sv -----
`default_nettype none
package tom_pkg;

	localparam int NUM_FILTERS     = 32;
	localparam int OBJS_PER_FILTER = 16;

	localparam int FIDX_W = 5;
	localparam int PT_W   = 16;
	localparam int ETA_W  = 14;
	localparam int PHI_W  = 13;
	localparam int MASK_W = 32;
	localparam int OBJ_W  = PT_W + ETA_W + PHI_W;

	localparam int FILT_W  = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
	localparam int SLOT_W  = (OBJS_PER_FILTER > 1) ? $clog2(OBJS_PER_FILTER) : 1;
	localparam int CNT_W   = $clog2(OBJS_PER_FILTER + 1);
	localparam int DEPTH   = NUM_FILTERS * OBJS_PER_FILTER;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int PTC_W      = 10;
	localparam int DR_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [PTC_W-1:0] PT_CUT_RST = PTC_W'(1023);
	localparam logic [DR_W-1:0]  DR_CUT_RST = DR_W'(307);

	localparam int PHI_PI     = 3217;
	localparam int PHI_TWO_PI = 6434;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PT_CUT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DR_CUT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_PT_EN  = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_REPLY
	} tom_state_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic load;
		logic scan;
	} tom_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic pipe_busy;
	} tom_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/tom_ram.sv -----
`default_nettype none
module tom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/tom_ctrl.sv -----
`default_nettype none
module tom_ctrl import tom_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic [1:0] func,
	input  wire tom_stat_t stat,
	output tom_cmd_t       cmd,
	output logic           busy,
	output logic           done
);

	tom_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && func == FUNC_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (func)
						FUNC_CLEAR:  cmd.clear  = 1'b1;
						FUNC_APPEND: cmd.append = 1'b1;
						FUNC_QUERY:  cmd.load   = 1'b1;
						default:     cmd        = '0;
					endcase
				end
			end
			ST_SCAN:  cmd.scan = 1'b1;
			ST_DRAIN: done = 1'b0;
			ST_REPLY: done = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/tom_dp.sv -----
`default_nettype none
module tom_dp import tom_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire tom_cmd_t                cmd,
	output tom_stat_t                    stat,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [FIDX_W-1:0]       filter_index,
	input  wire logic [PT_W-1:0]         obj_pt,
	input  wire logic signed [ETA_W-1:0] obj_eta,
	input  wire logic signed [PHI_W-1:0] obj_phi,
	output logic [MASK_W-1:0]            match_mask,
	output logic                         overflow_seen
);

	localparam logic signed [PHI_W:0] PI_D     = (PHI_W+1)'(PHI_PI);
	localparam logic signed [PHI_W:0] NEG_PI_D = -((PHI_W+1)'(PHI_PI));
	localparam logic signed [PHI_W:0] TWO_PI_D = (PHI_W+1)'(PHI_TWO_PI);
	localparam int SQ_W = 2 * ETA_W;
	localparam int PSQ_W = 2 * PHI_W;
	localparam int DSQ_W = 2 * DR_W;
	localparam int LIM_W = PT_W + PTC_W;

	// configuration
	logic [PTC_W-1:0] pt_cut_q;
	logic [DR_W-1:0]  dr_cut_q;
	logic             pt_en_q;
	logic [DSQ_W-1:0] dr_sq_q;

	// list state
	logic [CNT_W-1:0] counts_q [NUM_FILTERS];
	logic             ovf_q;

	// query object and scan
	logic [PT_W-1:0]         q_pt_q;
	logic signed [ETA_W-1:0] q_eta_q;
	logic signed [PHI_W-1:0] q_phi_q;
	logic [FILT_W-1:0]       scan_filt_q;
	logic [SLOT_W-1:0]       scan_slot_q;
	logic [MASK_W-1:0]       mask_q;

	logic [FILT_W-1:0] cnt_addr;
	logic [CNT_W-1:0]  cnt_rd;
	logic              fidx_ok;
	logic              list_full;
	logic              slot_live;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [OBJ_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [OBJ_W-1:0]  ram_rdata;

	logic              v_s1;
	logic [FILT_W-1:0] filt_s1;

	logic [PT_W-1:0]         tpt;
	logic signed [ETA_W-1:0] teta;
	logic signed [PHI_W-1:0] tphi;
	logic signed [ETA_W:0]   deta;
	logic signed [PHI_W:0]   dphi_raw, dphi_a, dphi;
	logic [PT_W-1:0]         adiff;

	logic                    v_s2;
	logic [FILT_W-1:0]       filt_s2;
	logic signed [ETA_W:0]   deta_s2;
	logic signed [PHI_W:0]   dphi_s2;
	logic [PT_W-1:0]         adiff_s2;
	logic [PT_W-1:0]         tpt_s2;

	logic signed [2*(ETA_W+1)-1:0] eta_sq;
	logic signed [2*(PHI_W+1)-1:0] phi_sq;
	logic [LIM_W-1:0]              pt_lim;

	logic              v_s3;
	logic [FILT_W-1:0] filt_s3;
	logic [SQ_W-1:0]   eta_sq_s3;
	logic [PSQ_W-1:0]  phi_sq_s3;
	logic [PT_W-1:0]   adiff_s3;
	logic [LIM_W-1:0]  pt_lim_s3;

	logic [SQ_W:0] r2;
	logic          pt_ok;
	logic          dr_ok;
	logic          hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_cut_q <= PT_CUT_RST;
			dr_cut_q <= DR_CUT_RST;
			pt_en_q  <= 1'b1;
			dr_sq_q  <= DSQ_W'(DR_CUT_RST) * DSQ_W'(DR_CUT_RST);
		end else begin
			dr_sq_q <= DSQ_W'(dr_cut_q) * DSQ_W'(dr_cut_q);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PT_CUT: pt_cut_q <= cfg_data[PTC_W-1:0];
					CFG_DR_CUT: dr_cut_q <= cfg_data[DR_W-1:0];
					CFG_PT_EN:  pt_en_q  <= cfg_data[0];
					default:    pt_en_q  <= pt_en_q;
				endcase
			end
		end
	end

	always_comb begin
		cnt_addr  = cmd.scan ? scan_filt_q : filter_index[FILT_W-1:0];
		cnt_rd    = counts_q[cnt_addr];
		fidx_ok   = (32'(filter_index) < NUM_FILTERS);
		list_full = (cnt_rd >= CNT_W'(OBJS_PER_FILTER));
		slot_live = (CNT_W'(scan_slot_q) < cnt_rd);

		ram_we    = cmd.append && fidx_ok && !list_full;
		ram_waddr = ADDR_W'(cnt_addr) * ADDR_W'(OBJS_PER_FILTER)
			+ ADDR_W'(cnt_rd[SLOT_W-1:0]);
		ram_wdata = {obj_pt, obj_eta, obj_phi};
		ram_raddr = ADDR_W'(scan_filt_q) * ADDR_W'(OBJS_PER_FILTER)
			+ ADDR_W'(scan_slot_q);

		stat.scan_last = (scan_filt_q == FILT_W'(NUM_FILTERS - 1))
			&& (scan_slot_q == SLOT_W'(OBJS_PER_FILTER - 1));
		stat.pipe_busy = v_s1 || v_s2 || v_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FILTERS; i++) begin
				counts_q[i] <= '0;
			end
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_FILTERS; i++) begin
				counts_q[i] <= '0;
			end
			ovf_q <= 1'b0;
		end else if (cmd.append && fidx_ok) begin
			if (list_full) begin
				ovf_q <= 1'b1;
			end else begin
				counts_q[cnt_addr] <= cnt_rd + CNT_W'(1);
			end
		end
	end

	tom_ram #(
		.WIDTH(OBJ_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_pt_q  <= obj_pt;
			q_eta_q <= obj_eta;
			q_phi_q <= obj_phi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_filt_q <= '0;
			scan_slot_q <= '0;
			mask_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			v_s1 <= cmd.scan && slot_live;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.load) begin
				scan_filt_q <= '0;
				scan_slot_q <= '0;
			end else if (cmd.scan) begin
				if (scan_slot_q == SLOT_W'(OBJS_PER_FILTER - 1)) begin
					scan_slot_q <= '0;
					scan_filt_q <= scan_filt_q + FILT_W'(1);
				end else begin
					scan_slot_q <= scan_slot_q + SLOT_W'(1);
				end
			end
			if (cmd.load) begin
				mask_q <= '0;
			end else if (hit) begin
				mask_q[filt_s3] <= 1'b1;
			end
		end
	end

	// stage 1: differences and phi wrap
	always_comb begin
		tpt      = ram_rdata[PHI_W+ETA_W +: PT_W];
		teta     = ram_rdata[PHI_W +: ETA_W];
		tphi     = ram_rdata[PHI_W-1:0];
		deta     = {q_eta_q[ETA_W-1], q_eta_q} - {teta[ETA_W-1], teta};
		dphi_raw = {q_phi_q[PHI_W-1], q_phi_q} - {tphi[PHI_W-1], tphi};
		dphi_a   = (dphi_raw > PI_D) ? dphi_raw - TWO_PI_D : dphi_raw;
		dphi     = (dphi_a < NEG_PI_D) ? dphi_a + TWO_PI_D : dphi_a;
		adiff    = (q_pt_q >= tpt) ? q_pt_q - tpt : tpt - q_pt_q;
	end

	always_ff @(posedge clk) begin
		filt_s1  <= scan_filt_q;
		filt_s2  <= filt_s1;
		deta_s2  <= deta;
		dphi_s2  <= dphi;
		adiff_s2 <= adiff;
		tpt_s2   <= tpt;
	end

	// stage 2: squares and pt limit
	always_comb begin
		eta_sq = deta_s2 * deta_s2;
		phi_sq = dphi_s2 * dphi_s2;
		pt_lim = LIM_W'(pt_cut_q) * LIM_W'(tpt_s2);
	end

	always_ff @(posedge clk) begin
		filt_s3   <= filt_s2;
		eta_sq_s3 <= eta_sq[SQ_W-1:0];
		phi_sq_s3 <= phi_sq[PSQ_W-1:0];
		adiff_s3  <= adiff_s2;
		pt_lim_s3 <= pt_lim;
	end

	// stage 3: cuts
	always_comb begin
		r2    = (SQ_W+1)'(eta_sq_s3) + (SQ_W+1)'(phi_sq_s3);
		dr_ok = (r2 < (SQ_W+1)'(dr_sq_q));
		pt_ok = !pt_en_q || ({adiff_s3, {PTC_W{1'b0}}} < pt_lim_s3);
		hit   = v_s3 && dr_ok && pt_ok;
	end

	assign match_mask    = mask_q;
	assign overflow_seen = ovf_q;

endmodule
`default_nettype wire

// ----- rtl/core/trigger_object_matcher.sv -----
`default_nettype none
// Trigger object matcher. Items are taken when start is high and busy low.
// Clear and append finish at the edge that takes them, with busy staying low,
// so one may follow every cycle. A query walks the whole object store, one
// entry per cycle through the single read port of the 512-entry memory, then
// drains a three-stage compare pipeline: done pulses for one cycle with
// match_mask and overflow_seen once the pipeline has drained, and busy is
// high until then. The receiver cannot stall; sample the result while
// done is high. Configuration writes are always ready and belong in idle time.
module trigger_object_matcher import tom_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              func,
	input  wire logic [FIDX_W-1:0]       filter_index,
	input  wire logic [PT_W-1:0]         obj_pt,
	input  wire logic signed [ETA_W-1:0] obj_eta,
	input  wire logic signed [PHI_W-1:0] obj_phi,
	output logic                         done,
	output logic [MASK_W-1:0]            match_mask,
	output logic                         overflow_seen,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	tom_cmd_t  cmd;
	tom_stat_t stat;

	tom_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	tom_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.filter_index (filter_index),
		.obj_pt       (obj_pt),
		.obj_eta      (obj_eta),
		.obj_phi      (obj_phi),
		.match_mask   (match_mask),
		.overflow_seen(overflow_seen)
	);

endmodule
`default_nettype wire

// ----- rtl/core/tom_checker.sv -----
`default_nettype none
module tom_checker import tom_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] func,
	input wire logic       done,
	input wire logic       overflow_seen
);

	// a query request holds the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_QUERY |=> busy)
		else $error("query request did not raise busy");

	// other requests finish at once
	a_quick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func != FUNC_QUERY |=> !busy)
		else $error("clear or append left the block busy");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a query");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not single or busy stuck");

	a_clear_flag: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_CLEAR |=> !overflow_seen)
		else $error("overflow flag survived a clear");

endmodule

bind trigger_object_matcher tom_checker u_tom_checker (.*);
`default_nettype wire
